FILE: rtl/assert_macros.svh
// assertion macros shared by checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");
`endif

FILE: rtl/dhem_pkg.sv
// ----------------------------------------------------------------------------
// dhem_pkg
// shared types and constants of the depth histogram equalizer
// ----------------------------------------------------------------------------
package dhem_pkg;
   localparam int BinCount = 16384;
   localparam int BinBits = $clog2(BinCount);
   localparam int CntBits = 19;
   localparam logic [CntBits-1:0] CntMax = '1;

   typedef enum logic [1:0] {
      FUNC_CLEAR = 2'd0,
      FUNC_COUNT = 2'd1,
      FUNC_CLOSE = 2'd2,
      FUNC_MAP   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      CSR_HAND_DEPTH   = 2'd0,
      CSR_HAND_PRESENT = 2'd1,
      CSR_HAND_WINDOW  = 2'd2
   } csr_idx_type;

   localparam logic KIND_PIXEL   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;
endpackage

FILE: rtl/dhem_ram.sv
// ----------------------------------------------------------------------------
// dhem_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module dhem_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

FILE: rtl/depth_histogram_equalize_mask.sv
// clear writes zero to every bin; count reads its bin, then writes it incremented;
// close reads and accumulates each bin in turn; a map of a zero depth answers from idle;
// other maps: bin read wait, cdf*255 load, 28 restoring divide steps (none with no points)
// one transaction at a time; busy stays high until it is done (zero-depth count and map stay idle)
// after reset a clearing pass sweeps the whole bin memory, busy high
// reset clears counters, not datapath; results carry a one-cycle strobe, the receiver cannot stall
// ----------------------------------------------------------------------------
// depth_histogram_equalize_mask
// two-pass histogram equalization of a depth frame with a hand window mask
// ----------------------------------------------------------------------------
module depth_histogram_equalize_mask (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_depth,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   output logic        rsp_valid,
   output logic        rsp_kind,
   output logic [7:0]  rsp_gray,
   output logic        rsp_in_hand,
   output logic [18:0] rsp_valid_points,
   output logic [18:0] rsp_hand_points
);
   import dhem_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b0_0000_0001,
      ST_CLEAR = 9'b0_0000_0010,
      ST_CRD   = 9'b0_0000_0100,  // count: wait for bin read
      ST_CWR   = 9'b0_0000_1000,  // count: write incremented bin
      ST_SRD   = 9'b0_0001_0000,  // close: read bin
      ST_SWR   = 9'b0_0010_0000,  // close: accumulate and write
      ST_MRD   = 9'b0_0100_0000,  // map: wait for bin read
      ST_MLD   = 9'b0_1000_0000,  // map: load cdf * 255
      ST_DIV   = 9'b1_0000_0000   // map: restoring divide
   } state_type;

   state_type            state_ff, state_in;
   logic [BinBits-1:0]   addr_ff, addr_in;
   logic [CntBits-1:0]   valid_ff, valid_in, hand_ff, hand_in, acc_ff, acc_in;
   logic [15:0]          hdepth_ff, hwin_ff;
   logic                 hpres_ff;
   logic [15:0]          depth_ff, depth_in;
   logic                 last_ff, last_in;  // close pass reached last bin
   logic                 hit_ff, hit_in;
   // divider: remainder and quotient, 28-bit dividend shifted in msb first
   logic [27:0]          dvd_ff, dvd_in;
   logic [CntBits:0]     rem_ff, rem_in;
   logic [8:0]           quo_ff, quo_in;
   logic [4:0]           step_ff, step_in;
   logic                 ram_we;
   logic [CntBits-1:0]   ram_wd, ram_rd;
   logic [CntBits:0]     sum, trial;
   logic                 win;
   logic [16:0]          lo, hi;
   logic                 out_v_in, out_k_in, out_h_in;
   logic [7:0]           out_g_in;
   logic [CntBits-1:0]   out_vp_in, out_hp_in;

   dhem_ram #(.Width(CntBits), .Depth(BinCount)) u_bins (
      .clock(clock), .wr_en(ram_we), .addr(addr_ff), .wr_data(ram_wd), .rd_data(ram_rd)
   );

   // hand window without wrap: lower bound may go below zero
   always_comb begin
      lo  = {1'b0, hdepth_ff} - {1'b0, hwin_ff};
      hi  = {1'b0, hdepth_ff} + {1'b0, hwin_ff};
      win = hpres_ff && (hdepth_ff != '0) &&
            (lo[16] || ({1'b0, depth_ff} >= lo)) && ({1'b0, depth_ff} <= hi);
   end

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;  addr_in = addr_ff;  valid_in = valid_ff;
      hand_in = hand_ff;    acc_in = acc_ff;    depth_in = depth_ff;
      last_in = last_ff;    hit_in = hit_ff;    dvd_in = dvd_ff;
      rem_in = rem_ff;      quo_in = quo_ff;    step_in = step_ff;
      ram_we = 1'b0;        ram_wd = '0;
      out_v_in = 1'b0;  out_k_in = KIND_PIXEL;  out_g_in = '0;  out_h_in = 1'b0;
      out_vp_in = '0;   out_hp_in = '0;
      sum = {1'b0, acc_ff} + {1'b0, ram_rd};
      trial = {rem_ff[CntBits-1:0], dvd_ff[27]} - {1'b0, valid_ff};
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               depth_in = req_depth;
               addr_in = (req_depth >= 16'(BinCount)) ? BinBits'(BinCount - 1)
                                                      : req_depth[BinBits-1:0];
               unique case (func_type'(req_func))
                  FUNC_CLEAR: begin
                     addr_in = '0;  valid_in = '0;  hand_in = '0;
                     state_in = ST_CLEAR;
                  end
                  FUNC_COUNT: if (req_depth != '0) state_in = ST_CRD;
                  FUNC_CLOSE: begin
                     addr_in = '0;  acc_in = '0;  last_in = 1'b0;
                     state_in = ST_SRD;
                  end
                  default: begin
                     if (req_depth == '0) begin
                        out_v_in = 1'b1;
                     end else begin
                        state_in = ST_MRD;
                     end
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            ram_we = 1'b1;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == BinBits'(BinCount - 1)) state_in = ST_IDLE;
         end
         ST_CRD: state_in = ST_CWR;
         ST_CWR: begin
            ram_we = 1'b1;
            ram_wd = (ram_rd == CntMax) ? CntMax : ram_rd + 1'b1;
            if (valid_ff != CntMax) valid_in = valid_ff + 1'b1;
            if (win && hand_ff != CntMax) hand_in = hand_ff + 1'b1;
            state_in = ST_IDLE;
         end
         ST_SRD: begin
            last_in = (addr_ff == BinBits'(BinCount - 1));
            state_in = ST_SWR;
         end
         ST_SWR: begin
            ram_we = 1'b1;
            ram_wd = sum[CntBits] ? CntMax : sum[CntBits-1:0];
            acc_in = ram_wd;
            if (last_ff) begin
               out_v_in = 1'b1;  out_k_in = KIND_SUMMARY;
               out_vp_in = valid_ff;  out_hp_in = hand_ff;
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
               state_in = ST_SRD;
            end
         end
         ST_MRD: state_in = ST_MLD;
         ST_MLD: begin
            hit_in = win;
            dvd_in = {1'b0, ram_rd, 8'd0} - {9'd0, ram_rd};  // cdf * 255
            rem_in = '0;  quo_in = '0;  step_in = '0;
            state_in = ST_DIV;
         end
         default: begin
            // one restoring step per cycle, remainder stays below divisor
            if (valid_ff == '0) begin
               out_v_in = 1'b1;  out_g_in = 8'd255;  out_h_in = hit_ff;
               state_in = ST_IDLE;
            end else begin
               if (!trial[CntBits]) begin
                  rem_in = trial;
                  quo_in = {quo_ff[7:0], 1'b1} | {quo_ff[8], 8'd0};
               end else begin
                  rem_in = {rem_ff[CntBits-1:0], dvd_ff[27]};
                  quo_in = {quo_ff[7:0], 1'b0} | {quo_ff[8], 8'd0};
               end
               dvd_in = {dvd_ff[26:0], 1'b0};
               step_in = step_ff + 1'b1;
               if (step_ff == 5'd27) begin
                  out_v_in = 1'b1;  out_h_in = hit_ff;
                  out_g_in = quo_in[8] ? 8'd0 : 8'd255 - quo_in[7:0];
                  state_in = ST_IDLE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // sweep the bin memory once after reset
         state_ff <= ST_CLEAR;
         addr_ff <= '0;  valid_ff <= '0;  hand_ff <= '0;
         hdepth_ff <= '0;  hpres_ff <= 1'b0;  hwin_ff <= 16'd100;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;  addr_ff <= addr_in;
         valid_ff <= valid_in;  hand_ff <= hand_in;
         rsp_valid <= out_v_in;
         if (csr_we) begin
            unique case (csr_idx_type'(csr_index))
               CSR_HAND_DEPTH:   hdepth_ff <= csr_data;
               CSR_HAND_PRESENT: hpres_ff <= csr_data[0];
               CSR_HAND_WINDOW:  hwin_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;  depth_ff <= depth_in;  last_ff <= last_in;  hit_ff <= hit_in;
      dvd_ff <= dvd_in;  rem_ff <= rem_in;  quo_ff <= quo_in;  step_ff <= step_in;
      rsp_kind <= out_k_in;  rsp_gray <= out_g_in;  rsp_in_hand <= out_h_in;
      rsp_valid_points <= out_vp_in;  rsp_hand_points <= out_hp_in;
   end
endmodule

FILE: rtl/dhem_checker.sv
// ----------------------------------------------------------------------------
// dhem_checker
// port-level checks of the equalizer
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module dhem_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_func,
   input logic [15:0] req_depth,
   input logic        rsp_valid,
   input logic        rsp_kind,
   input logic [7:0]  rsp_gray,
   input logic        rsp_in_hand,
   input logic [18:0] rsp_valid_points,
   input logic [18:0] rsp_hand_points
);
   import dhem_pkg::*;

   `ASSERT_IMPL(a_summary_no_gray, clock, reset, rsp_valid && rsp_kind,
                rsp_gray == 8'd0 && !rsp_in_hand)
   `ASSERT_IMPL(a_pixel_no_counts, clock, reset, rsp_valid && !rsp_kind,
                rsp_valid_points == '0 && rsp_hand_points == '0)
   `ASSERT_NEXT(a_zero_map, clock, reset, start && !busy && req_func == FUNC_MAP &&
                req_depth == '0, rsp_valid && rsp_gray == 8'd0 && !rsp_in_hand)
   `ASSERT_NEXT(a_no_rsp_clear, clock, reset, start && !busy && req_func == FUNC_CLEAR,
                !rsp_valid)
endmodule

bind depth_histogram_equalize_mask dhem_checker u_dhem_checker (.*);
